>>> design/alk_pkg.sv
// Shared constants, types and state codes for the append log key index.
`default_nettype none
package alk_pkg;

    localparam int ENTRIES     = 256;
    localparam int KEY_BITS    = 64;
    localparam int OFFSET_BITS = 32;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W       = $clog2(ENTRIES + 1);
    localparam int STRIDE_W    = 16;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd256;
    localparam logic                MODE_ADD     = 1'b0;
    localparam logic                MODE_FIND    = 1'b1;
    localparam logic [0:0]          REG_STRIDE   = 1'b0;

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic [KEY_BITS-1:0]    key;
        logic [OFFSET_BITS-1:0] off;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        t_entry           data;
    } t_wr_req;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } t_rd_req;

endpackage
`default_nettype wire

>>> design/alk_store.sv
// Entry memory holding key and offset pairs, one write port and one registered read port.
`default_nettype none
module alk_store (
    input  wire logic             i_clk,
    input  wire alk_pkg::t_wr_req i_wr,
    input  wire alk_pkg::t_rd_req i_rd,
    output alk_pkg::t_entry       o_rd_data
);
    import alk_pkg::*;

    t_entry r_mem [ENTRIES];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.idx];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

>>> design/append_log_key_offset_index.sv
// Top level of the append log key index: command port, sequencer, compare unit and APB register.
// Add: result registered in the cycle after the item is taken; busy stays low, so one add per cycle.
// Find: scans newest to oldest, one entry read per cycle from the single memory read port;
// each read is registered, then compared; a result is registered on the newest match, when the
// oldest entry misses, or on an empty log. Busy is high until the result is shown.
// Synchronous active-low reset clears count, offset counter, stride (256) and control.
`default_nettype none
module append_log_key_offset_index (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    output logic                                o_busy,
    input  wire logic                           i_mode,
    input  wire logic [63:0]                    i_key,
    output logic                                o_done,
    output logic                                o_hit,
    output logic [31:0]                         o_offset,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [alk_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [alk_pkg::PDATA_W-1:0]    pwdata,
    output logic [alk_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);
    import alk_pkg::*;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [OFFSET_BITS-1:0] r_next, n_next;
    logic [STRIDE_W-1:0]    r_stride;
    logic [KEY_BITS-1:0]    r_key, n_key;
    logic [IDX_W-1:0]       r_rd_idx, n_rd_idx;
    logic                   r_issuing, n_issuing;
    logic                   r_dv, n_dv;
    logic                   r_dlast, n_dlast;
    logic                   r_done, n_done;
    logic                   r_hit, n_hit;
    logic [OFFSET_BITS-1:0] r_off, n_off;

    t_wr_req                wr;
    t_rd_req                rd;
    t_entry                 rd_data;
    logic                   accept;
    logic                   cfg_wr;

    alk_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd      (rd),
        .o_rd_data (rd_data)
    );

    assign accept = i_start && (r_state == S_IDLE);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2:2] == REG_STRIDE) ? PDATA_W'(r_stride) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= STRIDE_RESET;
        end else if (cfg_wr && (paddr[2:2] == REG_STRIDE)) begin
            r_stride <= pwdata[STRIDE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_next    <= '0;
            r_issuing <= 1'b0;
            r_dv      <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_next    <= n_next;
            r_issuing <= n_issuing;
            r_dv      <= n_dv;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_rd_idx <= n_rd_idx;
        r_dlast  <= n_dlast;
        r_hit    <= n_hit;
        r_off    <= n_off;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_next    = r_next;
        n_key     = r_key;
        n_rd_idx  = r_rd_idx;
        n_issuing = r_issuing;
        n_dv      = 1'b0;
        n_dlast   = r_dlast;
        n_done    = 1'b0;
        n_hit     = r_hit;
        n_off     = r_off;
        wr        = '0;
        rd        = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_mode == MODE_ADD) begin
                        n_off  = r_next;
                        n_next = r_next + OFFSET_BITS'(r_stride);
                        n_done = 1'b1;
                        if (r_count < CNT_W'(ENTRIES)) begin
                            wr.en       = 1'b1;
                            wr.idx      = r_count[IDX_W-1:0];
                            wr.data.key = i_key[KEY_BITS-1:0];
                            wr.data.off = r_next;
                            n_count     = r_count + 1'b1;
                            n_hit       = 1'b1;
                        end else begin
                            n_hit = 1'b0;
                        end
                    end else begin
                        n_key = i_key[KEY_BITS-1:0];
                        if (r_count == '0) begin
                            n_done = 1'b1;
                            n_hit  = 1'b0;
                            n_off  = '0;
                        end else begin
                            n_rd_idx  = IDX_W'(r_count - 1'b1);
                            n_issuing = 1'b1;
                            n_state   = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_issuing) begin
                    rd.en   = 1'b1;
                    rd.idx  = r_rd_idx;
                    n_dv    = 1'b1;
                    n_dlast = (r_rd_idx == '0);
                    if (r_rd_idx == '0) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_rd_idx = r_rd_idx - 1'b1;
                    end
                end
                if (r_dv) begin
                    if (rd_data.key == r_key) begin
                        n_done    = 1'b1;
                        n_hit     = 1'b1;
                        n_off     = rd_data.off;
                        n_issuing = 1'b0;
                        n_dv      = 1'b0;
                        n_state   = S_IDLE;
                    end else if (r_dlast) begin
                        n_done    = 1'b1;
                        n_hit     = 1'b0;
                        n_off     = '0;
                        n_issuing = 1'b0;
                        n_dv      = 1'b0;
                        n_state   = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_hit    = r_hit;
    assign o_offset = 32'(r_off);

    a_add_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_mode == MODE_ADD)) |=> o_done)
        else $error("add item gave no result in the next cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("entry count beyond capacity");

    a_dv_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_state == S_SCAN))
        else $error("read data valid outside a scan");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_mode == MODE_ADD) && (r_count < CNT_W'(ENTRIES)))
        |=> (r_count == $past(r_count) + 1'b1) && o_hit)
        else $error("stored add did not advance the entry count");

    a_busy_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !wr.en)
        else $error("memory written during a scan");

endmodule
`default_nettype wire

>>> tb/sv/tb_append_log_key_offset_index.sv
// Testbench for the append log key index: directed table, then random traffic against a predictor.
module tb_append_log_key_offset_index;
    import alk_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = ENTRIES + 40;
    localparam int RAND_ITEMS     = 1600;
    localparam int PHASES         = 8;
    localparam int DIR_ROWS       = 16;
    localparam int WIDE_ADDS      = 24;

    localparam logic [PADDR_W-1:0] STRIDE_ADDR = {REG_STRIDE, 2'b00};
    localparam logic [PADDR_W-1:0] OTHER_ADDR  = {~REG_STRIDE, 2'b00};

    typedef struct packed {
        logic                   hit;
        logic [OFFSET_BITS-1:0] off;
    } t_lookup_res;

    typedef struct packed {
        logic                   mode;
        logic [KEY_BITS-1:0]    key;
        logic                   typed;
        logic                   hit;
        logic [OFFSET_BITS-1:0] off;
    } t_cmd_row;

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_start = 1'b0;
    logic                   i_mode  = MODE_ADD;
    logic [KEY_BITS-1:0]    i_key   = '0;
    logic                   psel    = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite  = 1'b0;
    logic [PADDR_W-1:0]     paddr   = '0;
    logic [PDATA_W-1:0]     pwdata  = '0;
    logic                   o_busy;
    logic                   o_done;
    logic                   o_hit;
    logic [OFFSET_BITS-1:0] o_offset;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    logic [KEY_BITS-1:0]    log_keys [ENTRIES];
    logic [OFFSET_BITS-1:0] log_offs [ENTRIES];
    int                     log_count = 0;
    logic [OFFSET_BITS-1:0] next_off  = '0;
    logic [STRIDE_W-1:0]    stride    = STRIDE_RESET;

    t_lookup_res pending_results [$];
    int          fail_cnt    = 0;
    int          burst_left  = 0;
    int          idle_cycles = 0;

    t_cmd_row dir_rows [DIR_ROWS] = '{
        '{MODE_FIND, 64'h0000_0000_0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{MODE_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
        '{MODE_ADD,  64'h0000_0000_0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{MODE_ADD,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 32'h0000_0100},
        '{MODE_FIND, 64'h0000_0000_0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{MODE_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 32'h0000_0100},
        '{MODE_ADD,  64'h0000_0000_0000_0000, 1'b1, 1'b1, 32'h0000_0200},
        '{MODE_FIND, 64'h0000_0000_0000_0000, 1'b1, 1'b1, 32'h0000_0200},
        '{MODE_FIND, 64'h8000_0000_0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{MODE_ADD,  64'h8000_0000_0000_0001, 1'b1, 1'b1, 32'h0000_0300},
        '{MODE_FIND, 64'h0000_0000_0000_0001, 1'b1, 1'b0, 32'h0000_0000},
        '{MODE_ADD,  64'h5555_5555_5555_5555, 1'b0, 1'b0, 32'h0000_0000},
        '{MODE_ADD,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 32'h0000_0000},
        '{MODE_FIND, 64'h5555_5555_5555_5555, 1'b0, 1'b0, 32'h0000_0000},
        '{MODE_FIND, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 32'h0000_0000},
        '{MODE_FIND, 64'h8000_0000_0000_0001, 1'b0, 1'b0, 32'h0000_0000}
    };

    append_log_key_offset_index uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_mode   (i_mode),
        .i_key    (i_key),
        .o_done   (o_done),
        .o_hit    (o_hit),
        .o_offset (o_offset),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_lookup_res index_step(input logic mode, input logic [KEY_BITS-1:0] key);
        t_lookup_res r;
        int          i;
        r = '0;
        if (mode == MODE_ADD) begin
            r.off = next_off;
            next_off = next_off + stride;
            if (log_count < ENTRIES) begin
                log_keys[log_count] = key;
                log_offs[log_count] = r.off;
                log_count++;
                r.hit = 1'b1;
            end
        end else begin
            for (i = 0; i < log_count; i++) begin
                if (log_keys[i] == key) begin
                    r.hit = 1'b1;
                    r.off = log_offs[i];
                end
            end
        end
        return r;
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_key();
        int                  sel;
        logic [KEY_BITS-1:0] k;
        sel = $urandom_range(0, 9);
        k = {$urandom, $urandom};
        if (log_count > 0 && sel >= 4 && sel <= 8) begin
            k = log_keys[$urandom_range(0, log_count - 1)];
        end else if (log_count > 0 && sel == 9) begin
            k = log_keys[$urandom_range(0, log_count - 1)] ^ (64'h1 << $urandom_range(0, 63));
        end else if (sel == 3) begin
            case ($urandom_range(0, 3))
                0: k = '0;
                1: k = '1;
                2: k = 64'h1;
                default: k = 64'h8000_0000_0000_0000;
            endcase
        end
        return k;
    endfunction

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        fail_cnt++;
        $error("%s mismatch: expected %0h, actual %0h", field, want, got);
    endtask

    always @(posedge i_clk) begin
        t_lookup_res want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                fail_cnt++;
                $error("result with no item pending: hit %0b offset %0h", o_hit, o_offset);
            end else begin
                want = pending_results.pop_front();
                if (o_hit !== want.hit)
                    note_mismatch("hit", 64'(want.hit), 64'(o_hit));
                if (o_offset !== want.off)
                    note_mismatch("offset", 64'(want.off), 64'(o_offset));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // hold start until taken, then either keep the burst going or drop start for a gap
    task automatic send_cmd(input logic mode, input logic [KEY_BITS-1:0] key,
                            input logic typed, input t_lookup_res typed_res);
        t_lookup_res r;
        i_start <= 1'b1;
        i_mode  <= mode;
        i_key   <= key;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        r = index_step(mode, key);
        pending_results.push_back(typed ? typed_res : r);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 6);
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if ((addr >> 2) == REG_STRIDE)
            stride = data[STRIDE_W-1:0];
    endtask

    initial begin
        int                  ph;
        int                  n;
        logic [STRIDE_W-1:0] new_stride;
        logic                mode;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < DIR_ROWS; n++)
            send_cmd(dir_rows[n].mode, dir_rows[n].key, dir_rows[n].typed,
                     '{dir_rows[n].hit, dir_rows[n].off});

        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: new_stride = '1;
                1: new_stride = '0;
                2: new_stride = 16'd1;
                default: new_stride = STRIDE_W'($urandom_range(1, 65535));
            endcase
            if (ph == 3)
                reg_write(OTHER_ADDR, {16'($urandom), 16'($urandom)});
            reg_write(STRIDE_ADDR, {16'($urandom), new_stride});
            for (n = 0; n < RAND_ITEMS / PHASES; n++) begin
                mode = ($urandom_range(0, 99) < 45) ? MODE_ADD : MODE_FIND;
                send_cmd(mode, pick_key(), 1'b0, '0);
            end
        end

        // advance the offset counter with the widest stride
        drain();
        reg_write(STRIDE_ADDR, {16'($urandom), 16'hFFFF});
        for (n = 0; n < WIDE_ADDS; n++)
            send_cmd(MODE_ADD, {$urandom, $urandom}, 1'b0, '0);
        for (n = 0; n < 8; n++)
            send_cmd(n[0] ? MODE_FIND : MODE_ADD, pick_key(), 1'b0, '0);

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
